[hdl/pidc_pkg.sv]
// shared types, constants and register indexes for the pid drive controller
package pidc_pkg;

   localparam int FRAC_BITS  = 8;
   localparam int VAL_W      = 16;
   localparam int ERR_W      = VAL_W + 1;
   localparam int ACC_W      = 32;
   localparam int LIMIT_W    = 31;
   localparam int DRIVE_W    = VAL_W + FRAC_BITS;
   localparam int OP_P_W     = ERR_W + 1;
   localparam int OP_D_W     = ERR_W + 2;
   localparam int PROD_P_W   = OP_P_W + VAL_W;
   localparam int PROD_I_W   = ACC_W + VAL_W;
   localparam int PROD_D_W   = OP_D_W + VAL_W;
   localparam int SUM_W      = PROD_I_W + 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = LIMIT_W;

   localparam logic MODE_INCREMENTAL = 1'b0;
   localparam logic MODE_POSITIONAL  = 1'b1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MODE,
      CSR_GAIN_P,
      CSR_GAIN_I,
      CSR_GAIN_D,
      CSR_OUT_UPPER,
      CSR_OUT_LOWER,
      CSR_INTEGRAL_LIMIT
   } csr_index_type;

   typedef struct packed {
      logic                      mode;
      logic signed [VAL_W-1:0]   gain_p;
      logic signed [VAL_W-1:0]   gain_i;
      logic signed [VAL_W-1:0]   gain_d;
      logic signed [VAL_W-1:0]   out_upper;
      logic signed [VAL_W-1:0]   out_lower;
      logic        [LIMIT_W-1:0] integral_limit;
   } cfg_type;

   typedef struct packed {
      logic                     mode;
      logic signed [OP_P_W-1:0] op_p;
      logic signed [ACC_W-1:0]  op_i;
      logic signed [OP_D_W-1:0] op_d;
   } oper_type;

endpackage

[hdl/pid_controller_dual_form_unit.sv]
// pid drive controller top level: csr bank, input stage, products, sum and clamp, output skid
//
//  channel  | dir | transfer when          | payload
//  ---------+-----+------------------------+---------------------------------------------
//  req      | in  | req_tvalid & tready    | tdata: setpoint[15:0], measured[31:16]
//  rsp      | out | rsp_tvalid & tready    | tdata: drive[15:0]; tuser: clamped
//  csr      | in  | csr_we                 | csr_addr register index, csr_wdata value
//
// one item per cycle sustained while rsp does not stall; a req reaches rsp valid via the
// input register, operand register, product register and result register
// the loops through error history, integral and last output each close in one stage
// a two-entry output buffer takes results while rsp stalls; req_tready is registered
// synchronous reset clears control, history, integral, last output and csr defaults
module pid_controller_dual_form_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // setpoint[15:0], measured[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // drive[15:0]
   output logic        rsp_tuser,   // clamped
   input  logic        csr_we,
   input  logic [pidc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [pidc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pidc_pkg::*;

   cfg_type                    cfg_ff;
   logic                       pipe_en;
   logic                       v0_ff, v1_ff, v2_ff;
   logic signed [VAL_W-1:0]    setpoint, measured;
   logic signed [ERR_W-1:0]    err0_ff;
   oper_type                   oper;
   logic                       mode2_ff;
   logic signed [PROD_P_W-1:0] prod_p_ff;
   logic signed [PROD_I_W-1:0] prod_i_ff;
   logic signed [PROD_D_W-1:0] prod_d_ff;
   logic signed [SUM_W-1:0]    sum, bound_hi, bound_lo, res;
   logic                       hit;
   logic signed [DRIVE_W-1:0]  last_drive_ff;
   logic                       produce, take;
   logic                       rsp_valid_ff, skid_valid_ff;
   logic [VAL_W-1:0]           rsp_drive_ff, skid_drive_ff, drive_in;
   logic                       rsp_clamp_ff, skid_clamp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= MODE_POSITIONAL;
         cfg_ff.gain_p         <= '0;
         cfg_ff.gain_i         <= '0;
         cfg_ff.gain_d         <= '0;
         cfg_ff.out_upper      <= VAL_W'(10000);
         cfg_ff.out_lower      <= -VAL_W'(10000);
         cfg_ff.integral_limit <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MODE:           cfg_ff.mode           <= csr_wdata[0];
            CSR_GAIN_P:         cfg_ff.gain_p         <= csr_wdata[VAL_W-1:0];
            CSR_GAIN_I:         cfg_ff.gain_i         <= csr_wdata[VAL_W-1:0];
            CSR_GAIN_D:         cfg_ff.gain_d         <= csr_wdata[VAL_W-1:0];
            CSR_OUT_UPPER:      cfg_ff.out_upper      <= csr_wdata[VAL_W-1:0];
            CSR_OUT_LOWER:      cfg_ff.out_lower      <= csr_wdata[VAL_W-1:0];
            CSR_INTEGRAL_LIMIT: cfg_ff.integral_limit <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign pipe_en    = !skid_valid_ff;
   assign req_tready = pipe_en;
   assign setpoint   = $signed(req_tdata[VAL_W-1:0]);
   assign measured   = $signed(req_tdata[2*VAL_W-1:VAL_W]);

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (pipe_en) begin
         v0_ff <= req_tvalid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   // input register holds the error
   always_ff @(posedge clock) begin
      if (pipe_en && req_tvalid) begin
         err0_ff <= ERR_W'(setpoint) - ERR_W'(measured);
      end
   end

   pidc_update u_update (
      .clock   (clock),
      .reset   (reset),
      .step_en (pipe_en && v0_ff),
      .err_in  (err0_ff),
      .cfg     (cfg_ff),
      .oper    (oper)
   );

   // gain products
   always_ff @(posedge clock) begin
      if (pipe_en && v1_ff) begin
         mode2_ff  <= oper.mode;
         prod_p_ff <= PROD_P_W'(cfg_ff.gain_p) * PROD_P_W'(oper.op_p);
         prod_i_ff <= PROD_I_W'(cfg_ff.gain_i) * PROD_I_W'(oper.op_i);
         prod_d_ff <= PROD_D_W'(cfg_ff.gain_d) * PROD_D_W'(oper.op_d);
      end
   end

   // sum and output clamp
   always_comb begin
      sum = SUM_W'(prod_p_ff) + SUM_W'(prod_i_ff) + SUM_W'(prod_d_ff);
      if (mode2_ff == MODE_INCREMENTAL) begin
         sum = sum + SUM_W'(last_drive_ff);
      end
      bound_hi = SUM_W'(cfg_ff.out_upper) <<< FRAC_BITS;
      bound_lo = SUM_W'(cfg_ff.out_lower) <<< FRAC_BITS;
      res      = sum;
      hit      = 1'b0;
      if (res > bound_hi) begin
         res = bound_hi;
         hit = 1'b1;
      end
      if (res < bound_lo) begin
         res = bound_lo;
         hit = 1'b1;
      end
      drive_in = res[DRIVE_W-1:FRAC_BITS];
   end

   assign produce = pipe_en && v2_ff;
   assign take    = rsp_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_drive_ff <= '0;
      end else if (produce && mode2_ff == MODE_INCREMENTAL) begin
         last_drive_ff <= res[DRIVE_W-1:0];
      end
   end

   // result register and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (produce) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            rsp_drive_ff <= skid_drive_ff;
            rsp_clamp_ff <= skid_clamp_ff;
         end
      end else if (produce) begin
         if (!rsp_valid_ff || take) begin
            rsp_drive_ff <= drive_in;
            rsp_clamp_ff <= hit;
         end else begin
            skid_drive_ff <= drive_in;
            skid_clamp_ff <= hit;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_drive_ff;
   assign rsp_tuser  = rsp_clamp_ff;

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a pending result");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      produce |=> rsp_valid_ff)
      else $error("finished result not presented");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready)
      |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result changed while waiting for transfer");

endmodule

[hdl/pidc_update.sv]
// error history, integral update and multiplier operand register
module pidc_update (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step_en,
   input  logic signed [pidc_pkg::ERR_W-1:0] err_in,
   input  pidc_pkg::cfg_type                cfg,
   output pidc_pkg::oper_type               oper
);
   import pidc_pkg::*;

   localparam logic signed [ACC_W+1:0] ACC_MAX = (ACC_W+2)'(2147483647);
   localparam logic signed [ACC_W+1:0] ACC_MIN = -(ACC_W+2)'(64'sd2147483648);

   logic signed [ERR_W-1:0]  err_now_ff, err_prev_ff, err_prev2_ff;
   logic signed [ERR_W-1:0]  err_now_in, err_prev_in, err_prev2_in;
   logic signed [ACC_W-1:0]  integ_ff, integ_in;
   logic signed [ACC_W+1:0]  acc_sum, acc_clip, limit_pos;
   logic signed [OP_P_W-1:0] diff1;
   logic signed [OP_D_W-1:0] diff2;
   oper_type                 oper_ff, oper_in;

   always_comb begin
      acc_sum   = (ACC_W+2)'(integ_ff) + (ACC_W+2)'(err_in);
      limit_pos = $signed({3'b000, cfg.integral_limit});
      acc_clip  = acc_sum;
      if (acc_clip > ACC_MAX) begin
         acc_clip = ACC_MAX;
      end
      if (acc_clip < ACC_MIN) begin
         acc_clip = ACC_MIN;
      end
      if (cfg.integral_limit != '0) begin
         if (acc_clip > limit_pos) begin
            acc_clip = limit_pos;
         end
         if (acc_clip < -limit_pos) begin
            acc_clip = -limit_pos;
         end
      end

      diff1 = OP_P_W'(err_in) - OP_P_W'(err_now_ff);
      diff2 = OP_D_W'(err_in) - (OP_D_W'(err_now_ff) <<< 1) + OP_D_W'(err_prev_ff);

      err_now_in   = err_in;
      err_prev_in  = err_now_ff;
      integ_in     = integ_ff;
      err_prev2_in = err_prev2_ff;
      oper_in.mode = cfg.mode;
      if (cfg.mode == MODE_INCREMENTAL) begin
         err_prev2_in = err_prev_ff;
         oper_in.op_p = diff1;
         oper_in.op_i = ACC_W'(err_in);
         oper_in.op_d = diff2;
      end else begin
         integ_in     = (cfg.gain_i == '0) ? '0 : acc_clip[ACC_W-1:0];
         oper_in.op_p = OP_P_W'(err_in);
         oper_in.op_i = integ_in;
         oper_in.op_d = OP_D_W'(diff1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_now_ff   <= '0;
         err_prev_ff  <= '0;
         err_prev2_ff <= '0;
         integ_ff     <= '0;
      end else if (step_en) begin
         err_now_ff   <= err_now_in;
         err_prev_ff  <= err_prev_in;
         err_prev2_ff <= err_prev2_in;
         integ_ff     <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         oper_ff <= oper_in;
      end
   end

   assign oper = oper_ff;

   a_integ_cleared: assert property (@(posedge clock) disable iff (reset)
      (step_en && cfg.mode == MODE_POSITIONAL && cfg.gain_i == '0) |=> integ_ff == '0)
      else $error("integral not cleared with zero integral gain");

   a_integ_limit: assert property (@(posedge clock) disable iff (reset)
      (step_en && cfg.mode == MODE_POSITIONAL && cfg.integral_limit != '0)
      |=> ((ACC_W+2)'(integ_ff) <= $signed({3'b000, $past(cfg.integral_limit)})
           && (ACC_W+2)'(integ_ff) >= -$signed({3'b000, $past(cfg.integral_limit)})))
      else $error("integral outside its limit");

   a_hist_shift: assert property (@(posedge clock) disable iff (reset)
      (step_en && cfg.mode == MODE_INCREMENTAL) |=> err_prev2_ff == $past(err_prev_ff))
      else $error("error history not shifted");

endmodule
